// ----- hdl/emadip_pkg.sv -----
// -----------------------------------------------------------------------------
// emadip_pkg
// Types and constants shared by the averaging dip detector with hysteresis.
// -----------------------------------------------------------------------------
package emadip_pkg;

  // Widths of the fixed fields.
  localparam int unsigned AlphaW    = 8;
  localparam int unsigned ThrW      = 12;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 12;

  // Register values after reset.
  localparam logic [AlphaW-1:0] AlphaReset     = 8'd26;
  localparam logic [ThrW-1:0]   ThresholdReset = 12'd227;
  localparam logic [ThrW-1:0]   HysteresisReset = 12'd68;
  localparam logic [LimitW-1:0] IdleLimitReset = 8'd10;

  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // Item kinds.
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_SET    = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_ALPHA      = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_HYSTERESIS = 2'd2,
    CFG_IDLE_LIMIT = 2'd3
  } cfg_idx_e;

endpackage

// ----- hdl/ema_dip_detector_hysteresis_unit.sv -----
// -----------------------------------------------------------------------------
// ema_dip_detector_hysteresis_unit
// Exponential average of light samples with dip counting, hysteresis and idle.
// -----------------------------------------------------------------------------
// Usage:
// Each input word carries an action (sample, countdown tick or set count), a
// sample and a new count value. Both channels use valid/ready. An accepted word
// is held in an input register; once the output register is free, the average
// update, the dip compare and the count update run in one pass and the result
// word is loaded into the output register together with the new detector state.
// One word is taken every cycle while the receiver keeps up. When the receiver
// stalls, the result waits in the output register and one further word can be
// taken into the input register; after that in_ready_o falls until the result
// is taken. The throughput is set by the state loop through the two multipliers
// of the average update, which closes in one pass.
// Reset clears both stages, sets the average, count and reference to zero, arms
// the detector, clears idle and loads the registers with their default values.
// Configuration writes take effect at once; the user must make them while the unit is idle (unchecked).
// -----------------------------------------------------------------------------
module ema_dip_detector_hysteresis_unit #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration port
  input  logic                                  cfg_we_i,
  input  logic [emadip_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [emadip_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  input  logic [emadip_pkg::CountW-1:0]         set_value_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [SAMPLE_BITS-1:0]                average_o,
  output logic [emadip_pkg::CountW-1:0]         dip_count_o,
  output logic                                  dip_found_o,
  output logic                                  armed_o,
  output logic                                  idle_o
);

  localparam int unsigned AccW = SAMPLE_BITS + 9;
  localparam int unsigned ThrSumW = emadip_pkg::ThrW + 1;
  localparam int unsigned CmpW = ((SAMPLE_BITS > ThrSumW) ? SAMPLE_BITS : ThrSumW) + 2;

  // Configuration registers.
  logic [emadip_pkg::AlphaW-1:0] alpha_q;
  logic [emadip_pkg::ThrW-1:0]   threshold_q;
  logic [emadip_pkg::ThrW-1:0]   hysteresis_q;
  logic [emadip_pkg::LimitW-1:0] idle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= emadip_pkg::AlphaReset;
      threshold_q  <= emadip_pkg::ThresholdReset;
      hysteresis_q <= emadip_pkg::HysteresisReset;
      idle_limit_q <= emadip_pkg::IdleLimitReset;
    end else if (cfg_we_i) begin
      case (emadip_pkg::cfg_idx_e'(cfg_index_i))
        emadip_pkg::CFG_ALPHA:      alpha_q <= cfg_wdata_i[emadip_pkg::AlphaW-1:0];
        emadip_pkg::CFG_THRESHOLD:  threshold_q <= cfg_wdata_i[emadip_pkg::ThrW-1:0];
        emadip_pkg::CFG_HYSTERESIS: hysteresis_q <= cfg_wdata_i[emadip_pkg::ThrW-1:0];
        emadip_pkg::CFG_IDLE_LIMIT: idle_limit_q <= cfg_wdata_i[emadip_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage.
  logic                          in_valid_q;
  logic [1:0]                    action_q;
  logic [SAMPLE_BITS-1:0]        sample_q;
  logic [emadip_pkg::CountW-1:0] set_value_q;
  logic                          out_valid_q;
  logic                          advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q    <= action_i;
      sample_q    <= sample_i;
      set_value_q <= set_value_i;
    end
  end

  // Detector state. The state after an item is exactly what its result reports,
  // and it only changes when the next result is loaded, so it drives the
  // output fields directly.
  logic [SAMPLE_BITS-1:0]        avg_q, avg_d;
  logic [emadip_pkg::CountW-1:0] count_q, count_d;
  logic                          armed_q, armed_d;
  logic [SAMPLE_BITS-1:0]        ref_q, ref_d;
  logic                          idle_q, idle_d;
  logic                          found_q, found_d;

  // Average update.
  logic [8:0]                 weight_old;
  logic [AccW-1:0]            acc;
  logic [SAMPLE_BITS-1:0]     avg_new;
  logic signed [CmpW-1:0]     diff_s;
  logic signed [CmpW-1:0]     thr_s;
  logic [ThrSumW-1:0]         thr;
  logic [SAMPLE_BITS-1:0]     back_abs;
  logic                       rearm_close;
  logic [emadip_pkg::CountW-1:0] count_sample;

  assign weight_old = 9'd256 - {1'b0, alpha_q};
  assign acc = AccW'(weight_old) * AccW'(avg_q) + AccW'(alpha_q) * AccW'(sample_q);
  assign avg_new = acc[SAMPLE_BITS+7:8];

  assign diff_s = $signed(CmpW'(avg_new)) - $signed(CmpW'(sample_q));
  assign thr = armed_q ? ThrSumW'(threshold_q)
                       : ThrSumW'(threshold_q) + ThrSumW'(hysteresis_q);
  assign thr_s = $signed(CmpW'(thr));

  assign back_abs = (ref_q >= sample_q) ? (ref_q - sample_q) : (sample_q - ref_q);
  assign rearm_close = CmpW'(back_abs) < CmpW'(hysteresis_q);

  assign count_sample = (count_q != emadip_pkg::CountMax) ? count_q + 1'b1 : count_q;

  always_comb begin
    avg_d   = avg_q;
    count_d = count_q;
    armed_d = armed_q;
    ref_d   = ref_q;
    idle_d  = idle_q;
    found_d = 1'b0;
    case (emadip_pkg::action_e'(action_q))
      emadip_pkg::ACT_SAMPLE: begin
        avg_d = avg_new;
        if (diff_s >= thr_s) begin
          if (armed_q) begin
            count_d = count_sample;
            ref_d   = avg_new;
            idle_d  = 1'b0;
            armed_d = 1'b0;
            found_d = 1'b1;
          end
        end else if (rearm_close) begin
          armed_d = 1'b1;
        end
        if (count_d >= emadip_pkg::CountW'(idle_limit_q)) begin
          idle_d = 1'b1;
        end
      end
      emadip_pkg::ACT_TICK: begin
        if (idle_q && armed_q && (count_q != '0)) begin
          count_d = count_q - 1'b1;
        end
      end
      emadip_pkg::ACT_SET: begin
        count_d = set_value_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      count_q     <= '0;
      armed_q     <= 1'b1;
      ref_q       <= '0;
      idle_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        avg_q   <= avg_d;
        count_q <= count_d;
        armed_q <= armed_d;
        ref_q   <= ref_d;
        idle_q  <= idle_d;
        found_q <= found_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = avg_q;
  assign dip_count_o = count_q;
  assign dip_found_o = found_q;
  assign armed_o     = armed_q;
  assign idle_o      = idle_q;

endmodule
